### design/ahp_pkg.sv
// Package for the altitude hold controller: field widths, fixed-point formats,
// register indexes and the derived widths of the shared multiplier datapath.
// Depends on nothing; used by altitude_hold_pid.
package ahp_pkg;

    function automatic int imax(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

    function automatic int imin(input int a, input int b);
        return (a < b) ? a : b;
    endfunction

    // Fixed-point format and filter length.
    localparam int FRAC_BITS = 4;
    localparam int TAPS      = 3;

    // Field and register widths.
    localparam int RAW_W     = 16;
    localparam int TILT_W    = 16;
    localparam int SET_W     = 13;
    localparam int ALT_W     = 16;
    localparam int DRIVE_W   = 14;
    localparam int GAIN_W    = 20;
    localparam int RANGE_W   = 12;
    localparam int ASTEP_W   = 12;
    localparam int DSTEP_W   = 10;
    localparam int DMAX_W    = 10;
    localparam int INTEG_W   = 21;

    localparam int S_TDATA_W  = ((RAW_W + TILT_W + SET_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((ALT_W + DRIVE_W + 7) / 8) * 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = imax(GAIN_W, imax(RANGE_W, DSTEP_W));

    // Limits.
    localparam int TILT_ONE          = 32768;
    localparam int ALT_CAP           = 2 ** ALT_W - 1;
    localparam int DRIVE_CAP         = 2 ** DRIVE_W - 1;
    localparam int INTEG_CAP         = 2 ** INTEG_W - 1;
    localparam int INTEG_LIMIT_WHOLE = 64200;
    localparam int INTEG_LIMIT       = imin(INTEG_LIMIT_WHOLE * (2 ** FRAC_BITS), INTEG_CAP);

    // Tilt rescale from Q1.15 product to FRAC_BITS fraction bits.
    localparam int SCALE_SHIFT = 15 - FRAC_BITS;
    localparam int SCALE_HALF  = 2 ** (14 - FRAC_BITS);

    // Average over TAPS by multiplying with a rounded-up reciprocal.
    localparam int TAP_SUM_W = ALT_W + $clog2(TAPS);
    localparam int DIV_SHIFT = TAP_SUM_W + $clog2(TAPS);
    localparam int DIV_RECIP = (2 ** DIV_SHIFT + TAPS - 1) / TAPS;

    // Datapath widths.
    localparam int ALT_SLEW_W = imax(ALT_W, ASTEP_W + FRAC_BITS) + 2;
    localparam int ERR_W      = imax(SET_W + FRAC_BITS, ALT_W) + 1;
    localparam int DERR_W     = ERR_W + 1;
    localparam int MUL_A_W    = imax(imax(DERR_W, INTEG_W + 1),
                                     imax(TAP_SUM_W + 1, RANGE_W + 1));
    localparam int MUL_B_W    = imax(imax(GAIN_W, TILT_W), $clog2(DIV_RECIP + 1));
    localparam int PROD_W     = MUL_A_W + MUL_B_W + 1;
    localparam int ACC_W      = PROD_W + 2;
    localparam int RND_SHIFT  = 16;
    localparam int DRV_W      = ACC_W - RND_SHIFT + 1;
    localparam int DSLEW_W    = DRV_W + 1;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P       = 3'd0,
        REG_GAIN_I       = 3'd1,
        REG_GAIN_D       = 3'd2,
        REG_RANGE_MIN    = 3'd3,
        REG_RANGE_MAX    = 3'd4,
        REG_ALT_STEP     = 3'd5,
        REG_DRIVE_STEP   = 3'd6,
        REG_DRIVE_MAX    = 3'd7
    } cfg_reg_t;

    // Register reset values.
    localparam logic [GAIN_W-1:0]  GAIN_P_RST     = GAIN_W'(9175);
    localparam logic [GAIN_W-1:0]  GAIN_I_RST     = GAIN_W'(328);
    localparam logic [GAIN_W-1:0]  GAIN_D_RST     = GAIN_W'(65536);
    localparam logic [RANGE_W-1:0] RANGE_MIN_RST  = RANGE_W'(50);
    localparam logic [RANGE_W-1:0] RANGE_MAX_RST  = RANGE_W'(4000);
    localparam logic [ASTEP_W-1:0] ALT_STEP_RST   = ASTEP_W'(100);
    localparam logic [DSTEP_W-1:0] DRIVE_STEP_RST = DSTEP_W'(50);
    localparam logic [DMAX_W-1:0]  DRIVE_MAX_RST  = DMAX_W'(600);

endpackage

### design/altitude_hold_pid.sv
// Altitude hold PID controller with tilt correction, tap averaging, anti-windup
// and slew limiting, built around one shared multiplier and a small sequencer.
// Depends on ahp_pkg.
//
// Usage: one input beat on s_* carries a raw height, a tilt factor and a
// target height in s_tdata, and the hold enable in s_tuser. Each input beat
// produces exactly one result beat on m_* with the filtered altitude and the
// controller drive. Gains and limits are written through the cfg_* channel,
// which is always ready; write it only while the block is idle.
// Results: m_tvalid rises when the sequencer leaves its output state. The
// block takes no new input beat until it is done with the last one; five
// multiplications (tilt, tap average, P, I, D) share the single multiplier.
// s_tready is high only while the sequencer is idle.
// A finished result sits in the output register, so the next input beat can
// be accepted while the receiver stalls; if a second result is ready before
// the first is taken, the sequencer holds it in its last state.
// Reset (aresetn low, synchronous) restores the register defaults and clears
// the filter taps, integrator and previous error, altitude and drive.
module altitude_hold_pid (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [ahp_pkg::S_TDATA_W-1:0]     s_tdata,   // raw_height, tilt_factor, set_height
    input  logic                              s_tuser,   // hold_enable
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [ahp_pkg::M_TDATA_W-1:0]     m_tdata,   // altitude, drive
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ahp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ahp_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ahp_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_TILT,
        ST_AVG,
        ST_MUL_AVG,
        ST_ALT,
        ST_ERR,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_ACC_D,
        ST_ROUND,
        ST_SLEW,
        ST_OUT
    } state_t;

    localparam logic signed [ACC_W:0] RND_HALF = (ACC_W + 1)'(2 ** (RND_SHIFT - 1));

    // Control and state registers.
    state_t               state_reg, state_next;
    logic [GAIN_W-1:0]    gain_p_reg, gain_p_next;
    logic [GAIN_W-1:0]    gain_i_reg, gain_i_next;
    logic [GAIN_W-1:0]    gain_d_reg, gain_d_next;
    logic [RANGE_W-1:0]   range_min_reg, range_min_next;
    logic [RANGE_W-1:0]   range_max_reg, range_max_next;
    logic [ASTEP_W-1:0]   alt_step_reg, alt_step_next;
    logic [DSTEP_W-1:0]   drive_step_reg, drive_step_next;
    logic [DMAX_W-1:0]    drive_max_reg, drive_max_next;
    logic [RANGE_W-1:0]   lvh_reg, lvh_next;
    logic [ALT_W-1:0]     taps_reg [TAPS-1];
    logic [ALT_W-1:0]     taps_next [TAPS-1];
    logic [ALT_W-1:0]     prev_alt_reg, prev_alt_next;
    logic signed [ERR_W-1:0] prev_err_reg, prev_err_next;
    logic [INTEG_W-1:0]   integ_reg, integ_next;
    logic [DRIVE_W-1:0]   prev_drive_reg, prev_drive_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [ALT_W-1:0]     out_alt_reg, out_alt_next;
    logic [DRIVE_W-1:0]   out_drive_reg, out_drive_next;

    // Datapath registers.
    logic [SET_W-1:0]           set_reg, set_next;
    logic                       hold_reg, hold_next;
    logic signed [MUL_A_W-1:0]  op_a_reg, op_a_next;
    logic [MUL_B_W-1:0]         op_b_reg, op_b_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ERR_W-1:0]    err_reg, err_next;
    logic signed [DRV_W-1:0]    drv_round_reg, drv_round_next;
    logic signed [DSLEW_W-1:0]  drv_slew_reg, drv_slew_next;

    // Combinational helpers.
    logic                       s_accept;
    logic                       out_load;
    logic [RAW_W-1:0]           in_raw;
    logic [TILT_W-1:0]          in_tilt;
    logic [TILT_W-1:0]          tilt_sat;
    logic [PROD_W-1:0]          scaled_wide;
    logic [ALT_W-1:0]           scaled;
    logic [TAP_SUM_W-1:0]       tap_sum;
    logic [ALT_W-1:0]           quot;
    logic signed [ALT_SLEW_W-1:0] a_now, a_prev, a_step, a_diff, a_slew;
    logic signed [ERR_W-1:0]    set_ext, alt_ext;
    logic signed [MUL_A_W:0]    i_base, i_sum;
    logic signed [DERR_W-1:0]   derr;
    logic signed [ACC_W:0]      rnd;
    logic signed [DSLEW_W-1:0]  d_now, d_prev, d_step, d_diff, d_max, d_clamp;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = M_TDATA_W'({out_drive_reg, out_alt_reg});

    assign in_raw  = s_tdata[RAW_W-1:0];
    assign in_tilt = s_tdata[RAW_W +: TILT_W];
    assign out_load = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    always_comb begin
        state_next      = state_reg;
        gain_p_next     = gain_p_reg;
        gain_i_next     = gain_i_reg;
        gain_d_next     = gain_d_reg;
        range_min_next  = range_min_reg;
        range_max_next  = range_max_reg;
        alt_step_next   = alt_step_reg;
        drive_step_next = drive_step_reg;
        drive_max_next  = drive_max_reg;
        lvh_next        = lvh_reg;
        taps_next       = taps_reg;
        prev_alt_next   = prev_alt_reg;
        prev_err_next   = prev_err_reg;
        integ_next      = integ_reg;
        prev_drive_next = prev_drive_reg;
        m_tvalid_next   = m_tvalid_reg;
        out_alt_next    = out_alt_reg;
        out_drive_next  = out_drive_reg;
        set_next        = set_reg;
        hold_next       = hold_reg;
        op_a_next       = op_a_reg;
        op_b_next       = op_b_reg;
        acc_next        = acc_reg;
        err_next        = err_reg;
        drv_round_next  = drv_round_reg;
        drv_slew_next   = drv_slew_reg;

        tilt_sat = (in_tilt > TILT_W'(TILT_ONE)) ? TILT_W'(TILT_ONE) : in_tilt;

        scaled_wide = PROD_W'(prod_reg + PROD_W'(SCALE_HALF)) >> SCALE_SHIFT;
        scaled = (scaled_wide > PROD_W'(ALT_CAP)) ? ALT_W'(ALT_CAP) : scaled_wide[ALT_W-1:0];
        tap_sum = TAP_SUM_W'(scaled) + TAP_SUM_W'(TAPS / 2);
        for (int i = 0; i < TAPS - 1; i++) begin
            tap_sum = tap_sum + TAP_SUM_W'(taps_reg[i]);
        end

        // Altitude slew limit against the previous altitude, then clamp.
        quot   = prod_reg[DIV_SHIFT +: ALT_W];
        a_now  = ALT_SLEW_W'(quot);
        a_prev = ALT_SLEW_W'(prev_alt_reg);
        a_step = ALT_SLEW_W'(alt_step_reg) <<< FRAC_BITS;
        a_diff = a_now - a_prev;
        if (a_diff > a_step) begin
            a_slew = a_prev + a_step;
        end else if (a_diff < -a_step) begin
            a_slew = a_prev - a_step;
        end else begin
            a_slew = a_now;
        end

        set_ext = ERR_W'(set_reg) <<< FRAC_BITS;
        alt_ext = ERR_W'(prev_alt_reg);

        i_base = hold_reg ? (MUL_A_W + 1)'(integ_reg) : '0;
        i_sum  = i_base + (MUL_A_W + 1)'(err_reg);
        derr   = DERR_W'(err_reg) - DERR_W'(prev_err_reg);
        rnd    = (ACC_W + 1)'(acc_reg) + RND_HALF;

        // Drive slew limit against the previous drive, then clamp.
        d_now  = DSLEW_W'(drv_round_reg);
        d_prev = DSLEW_W'(prev_drive_reg);
        d_step = DSLEW_W'(drive_step_reg) <<< FRAC_BITS;
        d_diff = d_now - d_prev;
        d_max  = DSLEW_W'(drive_max_reg) <<< FRAC_BITS;
        if (drv_slew_reg < 0) begin
            d_clamp = '0;
        end else if (drv_slew_reg > d_max) begin
            d_clamp = d_max;
        end else begin
            d_clamp = drv_slew_reg;
        end
        if (d_clamp > DSLEW_W'(DRIVE_CAP)) begin
            d_clamp = DSLEW_W'(DRIVE_CAP);
        end

        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_GAIN_P:     gain_p_next     = cfg_data[GAIN_W-1:0];
                REG_GAIN_I:     gain_i_next     = cfg_data[GAIN_W-1:0];
                REG_GAIN_D:     gain_d_next     = cfg_data[GAIN_W-1:0];
                REG_RANGE_MIN:  range_min_next  = cfg_data[RANGE_W-1:0];
                REG_RANGE_MAX:  range_max_next  = cfg_data[RANGE_W-1:0];
                REG_ALT_STEP:   alt_step_next   = cfg_data[ASTEP_W-1:0];
                REG_DRIVE_STEP: drive_step_next = cfg_data[DSTEP_W-1:0];
                REG_DRIVE_MAX:  drive_max_next  = cfg_data[DMAX_W-1:0];
                default: ;
            endcase
        end

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if ((in_raw >= RAW_W'(range_min_reg)) && (in_raw <= RAW_W'(range_max_reg))) begin
                        lvh_next = in_raw[RANGE_W-1:0];
                    end
                    set_next   = s_tdata[RAW_W + TILT_W +: SET_W];
                    hold_next  = s_tuser;
                    op_a_next  = MUL_A_W'(lvh_next);
                    op_b_next  = MUL_B_W'(tilt_sat);
                    state_next = ST_MUL_TILT;
                end
            end
            ST_MUL_TILT: state_next = ST_AVG;
            ST_AVG: begin
                taps_next[0] = scaled;
                for (int i = TAPS - 2; i > 0; i--) begin
                    taps_next[i] = taps_reg[i-1];
                end
                op_a_next  = MUL_A_W'(tap_sum);
                op_b_next  = MUL_B_W'(DIV_RECIP);
                state_next = ST_MUL_AVG;
            end
            ST_MUL_AVG: state_next = ST_ALT;
            ST_ALT: begin
                if (a_slew < 0) begin
                    prev_alt_next = '0;
                end else if (a_slew > ALT_SLEW_W'(ALT_CAP)) begin
                    prev_alt_next = ALT_W'(ALT_CAP);
                end else begin
                    prev_alt_next = a_slew[ALT_W-1:0];
                end
                state_next = ST_ERR;
            end
            ST_ERR: begin
                err_next   = set_ext - alt_ext;
                op_a_next  = MUL_A_W'(err_next);
                op_b_next  = MUL_B_W'(gain_p_reg);
                state_next = ST_MUL_P;
            end
            ST_MUL_P: begin
                // Anti-windup: with hold off the integrator restarts from the error alone,
                // and it is kept inside zero and the integrator limit.
                if (i_sum < 0) begin
                    integ_next = '0;
                end else if (i_sum > (MUL_A_W + 1)'(INTEG_LIMIT)) begin
                    integ_next = INTEG_W'(INTEG_LIMIT);
                end else begin
                    integ_next = i_sum[INTEG_W-1:0];
                end
                op_a_next  = MUL_A_W'(integ_next);
                op_b_next  = MUL_B_W'(gain_i_reg);
                state_next = ST_MUL_I;
            end
            ST_MUL_I: begin
                acc_next      = ACC_W'(prod_reg);
                op_a_next     = MUL_A_W'(derr);
                op_b_next     = MUL_B_W'(gain_d_reg);
                prev_err_next = err_reg;
                state_next    = ST_MUL_D;
            end
            ST_MUL_D: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_ACC_D;
            end
            ST_ACC_D: begin
                acc_next   = acc_reg + ACC_W'(prod_reg);
                state_next = ST_ROUND;
            end
            ST_ROUND: begin
                drv_round_next = DRV_W'(rnd >>> RND_SHIFT);
                state_next     = ST_SLEW;
            end
            ST_SLEW: begin
                if (d_diff > d_step) begin
                    drv_slew_next = d_prev + d_step;
                end else if (d_diff < -d_step) begin
                    drv_slew_next = d_prev - d_step;
                end else begin
                    drv_slew_next = d_now;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (out_load) begin
                    prev_drive_next = d_clamp[DRIVE_W-1:0];
                    out_drive_next  = d_clamp[DRIVE_W-1:0];
                    out_alt_next    = prev_alt_reg;
                    m_tvalid_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            gain_p_reg     <= GAIN_P_RST;
            gain_i_reg     <= GAIN_I_RST;
            gain_d_reg     <= GAIN_D_RST;
            range_min_reg  <= RANGE_MIN_RST;
            range_max_reg  <= RANGE_MAX_RST;
            alt_step_reg   <= ALT_STEP_RST;
            drive_step_reg <= DRIVE_STEP_RST;
            drive_max_reg  <= DRIVE_MAX_RST;
            lvh_reg        <= '0;
            for (int i = 0; i < TAPS - 1; i++) begin
                taps_reg[i] <= '0;
            end
            prev_alt_reg   <= '0;
            prev_err_reg   <= '0;
            integ_reg      <= '0;
            prev_drive_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            gain_p_reg     <= gain_p_next;
            gain_i_reg     <= gain_i_next;
            gain_d_reg     <= gain_d_next;
            range_min_reg  <= range_min_next;
            range_max_reg  <= range_max_next;
            alt_step_reg   <= alt_step_next;
            drive_step_reg <= drive_step_next;
            drive_max_reg  <= drive_max_next;
            lvh_reg        <= lvh_next;
            taps_reg       <= taps_next;
            prev_alt_reg   <= prev_alt_next;
            prev_err_reg   <= prev_err_next;
            integ_reg      <= integ_next;
            prev_drive_reg <= prev_drive_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    // Shared multiplier and its operand, accumulator and output registers.
    always_ff @(posedge aclk) begin
        set_reg       <= set_next;
        hold_reg      <= hold_next;
        op_a_reg      <= op_a_next;
        op_b_reg      <= op_b_next;
        prod_reg      <= op_a_reg * $signed({1'b0, op_b_reg});
        acc_reg       <= acc_next;
        err_reg       <= err_next;
        drv_round_reg <= drv_round_next;
        drv_slew_reg  <= drv_slew_next;
        out_alt_reg   <= out_alt_next;
        out_drive_reg <= out_drive_next;
    end

    // A new result only appears when the sequencer finishes an item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result beat raised outside the final step");

    // The altitude moves by no more than the step limit per item.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ALT) |=>
        (((prev_alt_reg >= $past(prev_alt_reg)) ?
          ALT_SLEW_W'(prev_alt_reg - $past(prev_alt_reg)) :
          ALT_SLEW_W'($past(prev_alt_reg) - prev_alt_reg))
         <= (ALT_SLEW_W'($past(alt_step_reg)) << FRAC_BITS)))
        else $error("altitude step exceeds the slew limit");

    // A loaded drive never exceeds the configured upper clamp.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=>
        (DSLEW_W'(out_drive_reg) <= (DSLEW_W'($past(drive_max_reg)) << FRAC_BITS)))
        else $error("drive above its upper clamp");

endmodule
